[hdl/recx_pkg.sv]
package recx_pkg;

	// coordinate and datapath widths
	localparam int COORD_W  = 16;
	localparam int CORNER_W = COORD_W + 2;   // holds p1 + p3 - p2
	localparam int DIFF_W   = CORNER_W + 1;  // difference of two corners
	localparam int PROD_W   = 2 * DIFF_W;    // one cross product term
	localparam int SUM_W    = PROD_W + 1;    // difference of the two terms

	// one corner point in the x-z plane
	typedef struct packed {
		logic signed [CORNER_W-1:0] x;
		logic signed [CORNER_W-1:0] z;
	} corner_t;

	// side of a point relative to a directed line
	typedef struct packed {
		logic pos;
		logic neg;
	} side_t;

	// widen a coordinate to corner width
	function automatic logic signed [CORNER_W-1:0] ext_coord(input logic [COORD_W-1:0] c);
		ext_coord = $signed({{(CORNER_W-COORD_W){c[COORD_W-1]}}, c});
	endfunction

	// exact difference of two corner coordinates
	function automatic logic signed [DIFF_W-1:0] diff(input logic signed [CORNER_W-1:0] a,
			input logic signed [CORNER_W-1:0] b);
		diff = $signed({a[CORNER_W-1], a}) - $signed({b[CORNER_W-1], b});
	endfunction

	// strictly opposite sides
	function automatic logic opposite(input side_t s, input side_t t);
		opposite = (s.pos && t.neg) || (s.neg && t.pos);
	endfunction

endpackage

[hdl/recx_orient.sv]
module recx_orient (
	input  logic             clk,
	input  recx_pkg::corner_t o,
	input  recx_pkg::corner_t p,
	input  recx_pkg::corner_t q,
	output recx_pkg::side_t  side
);
	import recx_pkg::*;

	logic signed [DIFF_W-1:0] pz_s2, px_s2, qz_s2, qx_s2;
	logic signed [PROD_W-1:0] m1_s3, m2_s3;
	logic signed [SUM_W-1:0]  d;
	side_t                    side_s4;

	// offsets from the line origin
	always_ff @(posedge clk) begin
		pz_s2 <= diff(p.z, o.z);
		px_s2 <= diff(p.x, o.x);
		qz_s2 <= diff(q.z, o.z);
		qx_s2 <= diff(q.x, o.x);
	end

	// the two cross product terms
	always_ff @(posedge clk) begin
		m1_s3 <= pz_s2 * qx_s2;
		m2_s3 <= px_s2 * qz_s2;
	end

	// exact difference, keep only its sign
	assign d = $signed({m1_s3[PROD_W-1], m1_s3}) - $signed({m2_s3[PROD_W-1], m2_s3});

	always_ff @(posedge clk) begin
		side_s4.neg <= d[SUM_W-1];
		side_s4.pos <= !d[SUM_W-1] && (d != '0);
	end

	assign side = side_s4;

endmodule

[hdl/rectangle_edge_crossing_test_core.sv]
// channel   ports                                   handshake
// -------   -------------------------------------   -------------------------------
// in word   ra_p1_x .. ra_p3_z, rb_p1_x .. rb_p3_z  taken when start && !busy
// out word  hit                                     shown for one cycle with done
//
// five register stages: corners and fourth corner, offsets, products,
// sign of the cross product, edge-pair combine
// a taken word moves through these stages in order and shows on done; one word per cycle
// busy never rises, since 32 orientation lanes run fully pipelined
// arst_n clears only the valid bits, the datapath carries no reset
module rectangle_edge_crossing_test_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [recx_pkg::COORD_W-1:0] ra_p1_x,
	input  logic [recx_pkg::COORD_W-1:0] ra_p1_z,
	input  logic [recx_pkg::COORD_W-1:0] ra_p2_x,
	input  logic [recx_pkg::COORD_W-1:0] ra_p2_z,
	input  logic [recx_pkg::COORD_W-1:0] ra_p3_x,
	input  logic [recx_pkg::COORD_W-1:0] ra_p3_z,
	input  logic [recx_pkg::COORD_W-1:0] rb_p1_x,
	input  logic [recx_pkg::COORD_W-1:0] rb_p1_z,
	input  logic [recx_pkg::COORD_W-1:0] rb_p2_x,
	input  logic [recx_pkg::COORD_W-1:0] rb_p2_z,
	input  logic [recx_pkg::COORD_W-1:0] rb_p3_x,
	input  logic [recx_pkg::COORD_W-1:0] rb_p3_z,
	output logic                        done,
	output logic                        hit
);
	import recx_pkg::*;

	corner_t a_s1 [4];
	corner_t b_s1 [4];
	logic    v_s1, v_s2, v_s3, v_s4, v_s5;
	side_t   sa [4][4];   // a edge i against b corner k
	side_t   sb [4][4];   // b edge j against a corner i
	logic    hit_s5;
	logic    any_cross;

	// accept a word in every cycle
	assign busy = 1'b0;

	// corners with the fourth one built from the other three
	always_ff @(posedge clk) begin
		a_s1[0].x <= ext_coord(ra_p1_x);
		a_s1[0].z <= ext_coord(ra_p1_z);
		a_s1[1].x <= ext_coord(ra_p2_x);
		a_s1[1].z <= ext_coord(ra_p2_z);
		a_s1[2].x <= ext_coord(ra_p3_x);
		a_s1[2].z <= ext_coord(ra_p3_z);
		a_s1[3].x <= ext_coord(ra_p1_x) + ext_coord(ra_p3_x) - ext_coord(ra_p2_x);
		a_s1[3].z <= ext_coord(ra_p1_z) + ext_coord(ra_p3_z) - ext_coord(ra_p2_z);
		b_s1[0].x <= ext_coord(rb_p1_x);
		b_s1[0].z <= ext_coord(rb_p1_z);
		b_s1[1].x <= ext_coord(rb_p2_x);
		b_s1[1].z <= ext_coord(rb_p2_z);
		b_s1[2].x <= ext_coord(rb_p3_x);
		b_s1[2].z <= ext_coord(rb_p3_z);
		b_s1[3].x <= ext_coord(rb_p1_x) + ext_coord(rb_p3_x) - ext_coord(rb_p2_x);
		b_s1[3].z <= ext_coord(rb_p1_z) + ext_coord(rb_p3_z) - ext_coord(rb_p2_z);
	end

	// valid bits follow the datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// orientation lanes, one per line and point pair
	for (genvar e = 0; e < 4; e++) begin : g_edge
		for (genvar c = 0; c < 4; c++) begin : g_corner
			recx_orient u_sa (
				.clk  (clk),
				.o    (a_s1[e]),
				.p    (b_s1[c]),
				.q    (a_s1[(e+1)%4]),
				.side (sa[e][c])
			);
			recx_orient u_sb (
				.clk  (clk),
				.o    (b_s1[e]),
				.p    (a_s1[c]),
				.q    (b_s1[(e+1)%4]),
				.side (sb[e][c])
			);
		end
	end

	// proper crossing of any edge pair
	always_comb begin
		any_cross = 1'b0;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				if (opposite(sb[j][i], sb[j][(i+1)%4]) &&
						opposite(sa[i][j], sa[i][(j+1)%4])) begin
					any_cross = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		hit_s5 <= any_cross;
	end

	assign done = v_s5;
	assign hit  = hit_s5;

`ifndef SYNTH
	// every accepted word comes out on done
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##5 done)
		else $error("accepted word did not come out");

	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result without accepted word");

	// a rectangle collapsed to one point has no edge that can cross
	a_point_rect: assert property (@(posedge clk) disable iff (!arst_n)
		(start && ra_p1_x == ra_p2_x && ra_p1_z == ra_p2_z &&
			ra_p3_x == ra_p2_x && ra_p3_z == ra_p2_z) |-> ##5 !hit)
		else $error("hit from a point rectangle");
`endif

endmodule
